// ----- hdl/start_length_frame_splitter_unit_defines.svh -----
// start_length_frame_splitter_unit_defines.svh
// assertion macros for the frame splitter; no dependencies
// expects a clock named clk and a reset named rst in the using module
`ifndef START_LENGTH_FRAME_SPLITTER_UNIT_DEFINES_SVH
`define START_LENGTH_FRAME_SPLITTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define SLFS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define SLFS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define SLFS_ASSERT_ALWAYS(label, cond, msg)
`define SLFS_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

// ----- hdl/slfs_pkg.sv -----
// slfs_pkg.sv
// shared types and constants of the start/length frame splitter
// no dependencies
package slfs_pkg;

  // parse phases
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_LEN_HI = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  // input action codes
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // start byte after reset
  localparam logic [7:0] START_BYTE_RST = 8'h68;

  // one parse result, valid low when the word yields nothing
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       abort;
  } slfs_result_t;

endpackage

// ----- hdl/start_length_frame_splitter_unit.sv -----
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | action, rx_byte
// out     | output    | out_valid/stall  | frame_byte, frame_first, frame_last, frame_abort
// cfg     | input     | cfg_write_en     | cfg_write_data (start byte)
//
// one word per clock sustained while no stalled output holds a word with a result;
// a word with a result passes the input register, the combinational parse step
// between the two registers, then the result register, before it shows at the output.
// reset clears the parse state to hunting and the start byte to 0x68.
// a stalled output holds the input register only for words that give a result;
// words dropped while hunting pass through regardless.
// start_length_frame_splitter_unit.sv: top level, depends on slfs_pkg,
// slfs_parser and start_length_frame_splitter_unit_defines.svh
`include "start_length_frame_splitter_unit_defines.svh"

module start_length_frame_splitter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_first,
  output logic       frame_last,
  output logic       frame_abort,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);
  import slfs_pkg::*;

  logic [7:0]   start_byte_q;
  logic         in_reg_valid;
  logic         in_reg_action;
  logic [7:0]   in_reg_byte;
  logic         advance;
  slfs_result_t res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte_q <= START_BYTE_RST;
    end else if (cfg_write_en) begin
      start_byte_q <= cfg_write_data;
    end
  end

  // parse step, consumes the input register word
  slfs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .action     (in_reg_action),
    .rx_byte    (in_reg_byte),
    .start_byte (start_byte_q),
    .res        (res)
  );

  // word leaves input register when it needs no output slot or one is free
  assign advance  = in_reg_valid && (!res.valid || !out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_action <= action;
      in_reg_byte   <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      frame_byte  <= res.data;
      frame_first <= res.first;
      frame_last  <= res.last;
      frame_abort <= res.abort;
    end
  end

  // checks
  `SLFS_ASSERT_IMPLIES(a_stall_needs_word, in_stall, in_reg_valid, "stall with empty input register")
  `SLFS_ASSERT_IMPLIES(a_abort_clean, out_valid && frame_abort, frame_byte == 8'd0 && !frame_first && !frame_last, "abort word carries data")
  `SLFS_ASSERT_IMPLIES(a_first_not_last, out_valid, !(frame_first && frame_last), "first and last on one word")

endmodule

// ----- hdl/slfs_parser.sv -----
// slfs_parser.sv
// frame parse state and the one-word step logic
// depends on slfs_pkg
module slfs_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  action,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            start_byte,
  output slfs_pkg::slfs_result_t res
);
  import slfs_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] len;

  assign len = {rx_byte, length_low};

  // next state and result for the word at the parser input
  always_comb begin
    phase_next      = phase;
    length_low_next = length_low;
    bytes_left_next = bytes_left;
    res             = '0;
    if (action == ACT_CLEAR) begin
      phase_next      = PH_HUNT;
      length_low_next = '0;
      bytes_left_next = '0;
      if (phase != PH_HUNT) begin
        res.valid = 1'b1;
        res.abort = 1'b1;
      end
    end else begin
      res.data = rx_byte;
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == start_byte) begin
            phase_next = PH_LEN_LO;
            res.valid  = 1'b1;
            res.first  = 1'b1;
          end
        end
        PH_LEN_LO: begin
          length_low_next = rx_byte;
          phase_next      = PH_LEN_HI;
          res.valid       = 1'b1;
        end
        PH_LEN_HI: begin
          res.valid = 1'b1;
          if (len == 16'd0) begin
            phase_next      = PH_HUNT;
            length_low_next = '0;
            bytes_left_next = '0;
            res.last        = 1'b1;
          end else begin
            bytes_left_next = len;
            phase_next      = PH_BODY;
          end
        end
        default: begin
          res.valid = 1'b1;
          if (bytes_left <= 16'd1) begin
            phase_next      = PH_HUNT;
            length_low_next = '0;
            bytes_left_next = '0;
            res.last        = 1'b1;
          end else begin
            bytes_left_next = bytes_left - 16'd1;
          end
        end
      endcase
    end
  end

  // state update when a word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      length_low <= '0;
      bytes_left <= '0;
    end else if (step) begin
      phase      <= phase_next;
      length_low <= length_low_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top.sv: self-checking testbench of start_length_frame_splitter_unit
// holds its own frame parser model and a queue of expected output words
// depends on slfs_pkg and the unit's rtl
module tb_top;
  import slfs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_GUARD  = 5000;
  localparam int SETTLE       = 8;
  localparam int PHASE_WORDS  = 120;
  localparam int HOLD_CYCLES  = 150;

  localparam slfs_result_t NO_WORD    = '0;
  localparam slfs_result_t ABORT_WORD = '{valid: 1'b1, data: 8'h00, first: 1'b0,
                                          last: 1'b0, abort: 1'b1};

  // one directed stimulus row, want is used only when pinned is set
  typedef struct packed {
    logic         act;
    logic [7:0]   b;
    logic         pinned;
    slfs_result_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = ACT_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_first;
  logic       frame_last;
  logic       frame_abort;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = 8'h00;

  // parser model state
  logic [1:0]  pr_phase = PH_HUNT;
  logic [7:0]  pr_len_lo = 8'h00;
  logic [15:0] pr_left = 16'h0000;
  logic [7:0]  pr_start = START_BYTE_RST;

  slfs_result_t pending_words[$];
  int bad_words = 0;
  int fed = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit gapless = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  script_row_t script [25];

  start_length_frame_splitter_unit uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .frame_first   (frame_first),
    .frame_last    (frame_last),
    .frame_abort   (frame_abort),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic note_bad(input string msg);
    if (bad_words < 10) $display("mismatch: %s", msg);
    bad_words++;
  endtask

  // parser model: one input word in, at most one frame word out
  function automatic slfs_result_t parse_word(input logic act, input logic [7:0] b);
    slfs_result_t r;
    logic [15:0]  flen;
    r = NO_WORD;
    if (act == ACT_CLEAR) begin
      if (pr_phase != PH_HUNT) r = ABORT_WORD;
      pr_phase  = PH_HUNT;
      pr_len_lo = 8'h00;
      pr_left   = 16'h0000;
      return r;
    end
    r.valid = 1'b1;
    r.data  = b;
    case (pr_phase)
      PH_HUNT: begin
        if (b != pr_start) begin
          r.valid = 1'b0;
        end else begin
          pr_phase = PH_LEN_LO;
          r.first  = 1'b1;
        end
      end
      PH_LEN_LO: begin
        pr_len_lo = b;
        pr_phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        flen = {b, pr_len_lo};
        if (flen == 16'h0000) begin
          // empty body, header ends the frame
          pr_phase  = PH_HUNT;
          pr_len_lo = 8'h00;
          pr_left   = 16'h0000;
          r.last    = 1'b1;
        end else begin
          pr_left  = flen;
          pr_phase = PH_BODY;
        end
      end
      default: begin
        if (pr_left <= 16'd1) begin
          pr_phase  = PH_HUNT;
          pr_len_lo = 8'h00;
          pr_left   = 16'h0000;
          r.last    = 1'b1;
        end else begin
          pr_left = pr_left - 16'd1;
        end
      end
    endcase
    return r;
  endfunction

  // offer one word, wait for acceptance, then record what it should yield
  task automatic send_word(input logic act, input logic [7:0] b,
                           input logic pinned, input slfs_result_t want);
    slfs_result_t r;
    if (!quiet && !gapless && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    r = parse_word(act, b);
    if (pinned) r = want;
    if (r.valid) pending_words.push_back(r);
    fed++;
  endtask

  task automatic send_plain(input logic act, input logic [7:0] b);
    send_word(act, b, 1'b0, NO_WORD);
  endtask

  // stop offering and let every expected word come out
  task automatic drain_words();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_words.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start_byte(input logic [7:0] v);
    drain_words();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    pr_start = v;
    cfg_write_en <= 1'b0;
  endtask

  // well-formed frame with random body
  task automatic send_frame(input logic [15:0] flen);
    send_plain(ACT_BYTE, pr_start);
    send_plain(ACT_BYTE, flen[7:0]);
    send_plain(ACT_BYTE, flen[15:8]);
    for (int i = 0; i < flen; i++) send_plain(ACT_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // one random piece of stream: mostly good frames, some noise and cut frames
  task automatic random_piece();
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_plain(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 12) begin
      send_plain(ACT_CLEAR, 8'($urandom_range(0, 255)));
    end else if (pick < 24) begin
      // frame cut short by a link loss somewhere in header or body
      cut = $urandom_range(1, 6);
      send_plain(ACT_BYTE, pr_start);
      for (int i = 1; i < cut; i++) send_plain(ACT_BYTE, 8'($urandom_range(0, 255)));
      send_plain(ACT_CLEAR, 8'($urandom_range(0, 255)));
    end else if (pick < 32) begin
      send_frame(16'($urandom_range(9, 40)));
    end else begin
      send_frame(16'($urandom_range(0, 8)));
    end
  endtask

  task automatic random_phase(input int words);
    fed = 0;
    while (fed < words) random_piece();
  endtask

  // output side stall bursts, plus one long hold-off on request
  always begin
    @(posedge clk);
    if (!rst) begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    slfs_result_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        note_bad($sformatf("unexpected word byte %h first %b last %b abort %b",
                           frame_byte, frame_first, frame_last, frame_abort));
      end else begin
        exp_w = pending_words.pop_front();
        if (frame_byte !== exp_w.data || frame_first !== exp_w.first ||
            frame_last !== exp_w.last || frame_abort !== exp_w.abort)
          note_bad($sformatf("exp byte %h f%b l%b a%b, got byte %h f%b l%b a%b",
                             exp_w.data, exp_w.first, exp_w.last, exp_w.abort,
                             frame_byte, frame_first, frame_last, frame_abort));
      end
    end
  end

  // stimulus
  initial begin
    script = '{
      // hunting: noise and a clear give nothing
      '{ACT_BYTE,  8'h00, 1'b1, NO_WORD},
      '{ACT_CLEAR, 8'h00, 1'b1, NO_WORD},
      // zero length frame ends on the second length byte
      '{ACT_BYTE,  8'h68, 1'b1, '{1'b1, 8'h68, 1'b1, 1'b0, 1'b0}},
      '{ACT_BYTE,  8'h00, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1, 1'b0}},
      // two byte body with extreme values
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h02, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h00, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'hFF, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h00, 1'b0, NO_WORD},
      // maximum length, cut by a clear in the body
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'hFF, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'hFF, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_CLEAR, 8'hFF, 1'b1, ABORT_WORD},
      // clear after the start byte, then after the low length byte
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_CLEAR, 8'h00, 1'b1, ABORT_WORD},
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h01, 1'b0, NO_WORD},
      '{ACT_CLEAR, 8'h55, 1'b1, ABORT_WORD},
      // one byte body
      '{ACT_BYTE,  8'h68, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h01, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h00, 1'b0, NO_WORD},
      '{ACT_BYTE,  8'h55, 1'b0, NO_WORD},
      '{ACT_CLEAR, 8'hFF, 1'b1, NO_WORD}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].act, script[i].b, script[i].pinned, script[i].want);

    set_start_byte(8'h00);
    random_phase(PHASE_WORDS);

    // long frame against a held-off output so the unit backs up
    set_start_byte(8'hFF);
    gapless = 1'b1;
    hold_req = 1'b1;
    send_frame(16'd40);
    gapless = 1'b0;
    random_phase(PHASE_WORDS);

    set_start_byte(8'($urandom_range(0, 255)));
    random_phase(PHASE_WORDS);

    // closing stretch with no idling on either side
    set_start_byte(START_BYTE_RST);
    quiet = 1'b1;
    random_phase(PHASE_WORDS);

    drain_words();
    if (pending_words.size() != 0)
      note_bad($sformatf("%0d expected words never arrived", pending_words.size()));

    if (bad_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/slfs_pkg.sv
hdl/slfs_parser.sv
hdl/start_length_frame_splitter_unit.sv
tb/tb_top.sv
